// File: rtl/spq_pkg.sv
// Shared types, widths and codes for the sorted priority queue.
// Depends on nothing; every other file refers to it by scoped names.
package spq_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	localparam int POS_W    = 4;
	localparam int CMD_W    = 2;
	localparam int STAT_W   = 2;
	localparam int ECNT_W   = 5;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	// Stream payload widths, rounded up to whole bytes.
	localparam int S_TDATA_W = ((DATA_W + POS_W + 7) / 8) * 8;
	localparam int S_TUSER_W = ((CMD_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((DATA_W + ECNT_W + 7) / 8) * 8;
	localparam int M_TUSER_W = ((STAT_W + 7) / 8) * 8;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

	localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;
	localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;  // latch the incoming beat
		logic exec;     // run the latched command and load the result
	} ctrl_cmd_t;

endpackage

// File: rtl/sorted_priority_queue_top.sv
// Sorted priority queue, top level: joins spq_ctrl and spq_datapath, widths from spq_pkg.
// An accepted command beat is captured into the input register, run in the execute state, and
// its result is registered there and held until the result beat is taken.
// Commands do not overlap: no beat is taken while one executes, and the next beat can be
// taken in the same cycle the pending result is taken.
// Reset (arst_n, asynchronous, active low) empties the list and drops any pending result.
module sorted_priority_queue_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// Command stream.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [spq_pkg::S_TDATA_W-1:0]     s_tdata,  // [31:0] value, [35:32] position
	input  logic [spq_pkg::S_TUSER_W-1:0]     s_tuser,  // [1:0] command
	// Result stream.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [spq_pkg::M_TDATA_W-1:0]     m_tdata,  // [31:0] read_value, [36:32] entry_count
	output logic [spq_pkg::M_TUSER_W-1:0]     m_tuser   // [1:0] status
);

	spq_pkg::ctrl_cmd_t                cmd;
	logic [spq_pkg::STAT_W-1:0]        status;
	logic signed [spq_pkg::DATA_W-1:0] read_value;
	logic [spq_pkg::ECNT_W-1:0]        entry_count;

	// The controller owns both handshakes and tells the datapath when to
	// capture a beat and when to run it.
	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// The datapath holds the list in compare-and-shift cells; every cell
	// decides its own next value in the execute cycle. Entry storage is not
	// cleared by reset, since only entries below the count are ever read.
	spq_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_command  (s_tuser[spq_pkg::CMD_W-1:0]),
		.in_value    (s_tdata[spq_pkg::DATA_W-1:0]),
		.in_position (s_tdata[spq_pkg::DATA_W +: spq_pkg::POS_W]),
		.status      (status),
		.read_value  (read_value),
		.entry_count (entry_count)
	);

	// Pack the result beat; unused upper bits are zero.
	assign m_tdata = {{(spq_pkg::M_TDATA_W - spq_pkg::DATA_W - spq_pkg::ECNT_W){1'b0}},
	                  entry_count, read_value};
	assign m_tuser = {{(spq_pkg::M_TUSER_W - spq_pkg::STAT_W){1'b0}}, status};

endmodule

// File: rtl/spq_ctrl.sv
// Controller for the sorted priority queue: handshake and sequencing.
// Depends on spq_pkg for the command struct.
module spq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output spq_pkg::ctrl_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic m_valid_q;
	logic accept;

	// A new beat is taken only when the result register is empty or drains now.
	assign s_tready    = (state_q == ST_IDLE) && (!m_valid_q || m_tready);
	assign accept      = s_tvalid && s_tready;
	assign m_tvalid    = m_valid_q;
	assign cmd.capture = accept;
	assign cmd.exec    = (state_q == ST_EXEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (state_q == ST_EXEC) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	a_exec_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) |=> m_valid_q)
		else $error("result not presented after execute");

	a_no_accept_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC) |-> !s_tready)
		else $error("input ready while a command executes");

	a_accept_starts_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_EXEC))
		else $error("accepted beat did not start execution");

endmodule

// File: rtl/spq_datapath.sv
// Datapath for the sorted priority queue: input register, a row of
// compare-and-shift cells, the entry count and the result register.
// Depends on spq_pkg for widths, codes and the command struct.
module spq_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  spq_pkg::ctrl_cmd_t               cmd,
	input  logic [spq_pkg::CMD_W-1:0]        in_command,
	input  logic signed [spq_pkg::DATA_W-1:0] in_value,
	input  logic [spq_pkg::POS_W-1:0]        in_position,
	output logic [spq_pkg::STAT_W-1:0]       status,
	output logic signed [spq_pkg::DATA_W-1:0] read_value,
	output logic [spq_pkg::ECNT_W-1:0]       entry_count
);

	logic [spq_pkg::CMD_W-1:0]         cmd_q;
	logic signed [spq_pkg::DATA_W-1:0] val_q;
	logic [spq_pkg::POS_W-1:0]         pos_q;
	logic [spq_pkg::CNT_W-1:0]         count_q;
	logic [spq_pkg::DATA_W-1:0]        ent_q [spq_pkg::CAPACITY];

	logic [spq_pkg::CAPACITY-1:0]      gt;
	logic [spq_pkg::CAPACITY-1:0]      eq;
	logic [spq_pkg::CAPACITY-1:0]      past_hit;
	logic [spq_pkg::DATA_W-1:0]        ins_next [spq_pkg::CAPACITY];
	logic [spq_pkg::DATA_W-1:0]        rem_next [spq_pkg::CAPACITY];

	logic                              full;
	logic                              found;
	logic                              in_range;
	logic [spq_pkg::CMP_W-1:0]         pos_c;
	logic [spq_pkg::IDX_W-1:0]         rd_idx;
	logic                              do_ins;
	logic                              do_rem;
	logic [spq_pkg::CNT_W-1:0]         count_next;
	logic [spq_pkg::STAT_W-1:0]        stat_next;
	logic [spq_pkg::DATA_W-1:0]        rd_next;

	// Each cell compares its own entry with the command value.
	for (genvar i = 0; i < spq_pkg::CAPACITY; i++) begin : g_cell
		logic live;
		assign live     = spq_pkg::CNT_W'(i) < count_q;
		assign gt[i]    = live && ($signed(ent_q[i]) > val_q);
		assign eq[i]    = live && (ent_q[i] == val_q);
		assign past_hit[i] = |eq[i:0];

		// Entries are descending, so gt is a prefix; the slot just after it takes the value.
		if (i == 0) begin : g_head
			assign ins_next[i] = gt[i] ? ent_q[i] : val_q;
		end else begin : g_body
			assign ins_next[i] = gt[i] ? ent_q[i] : (gt[i-1] ? val_q : ent_q[i-1]);
		end

		// At and after the first match, each cell pulls from its lower neighbor.
		if (i == spq_pkg::CAPACITY - 1) begin : g_tail
			assign rem_next[i] = ent_q[i];
		end else begin : g_mid
			assign rem_next[i] = past_hit[i] ? ent_q[i+1] : ent_q[i];
		end

		always_ff @(posedge clk) begin
			if (do_ins) begin
				ent_q[i] <= ins_next[i];
			end else if (do_rem) begin
				ent_q[i] <= rem_next[i];
			end
		end
	end

	assign full     = (count_q == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
	assign found    = |eq;
	assign pos_c    = spq_pkg::CMP_W'(pos_q);
	assign in_range = (pos_c < spq_pkg::CMP_W'(count_q)) &&
	                  (pos_c < spq_pkg::CMP_W'(spq_pkg::CAPACITY));
	assign rd_idx   = spq_pkg::IDX_W'(pos_c);
	assign do_ins   = cmd.exec && (cmd_q == spq_pkg::CMD_INSERT) && !full;
	assign do_rem   = cmd.exec && (cmd_q == spq_pkg::CMD_REMOVE) && found;

	always_comb begin
		count_next = count_q;
		stat_next  = spq_pkg::STAT_DONE;
		rd_next    = '0;
		unique case (cmd_q)
			spq_pkg::CMD_INSERT: begin
				if (full) begin
					stat_next = spq_pkg::STAT_FULL;
				end else begin
					count_next = count_q + 1'b1;
				end
			end
			spq_pkg::CMD_REMOVE: begin
				if (found) begin
					count_next = count_q - 1'b1;
				end else begin
					stat_next = spq_pkg::STAT_NOT_FOUND;
				end
			end
			spq_pkg::CMD_READ: begin
				if (in_range) begin
					rd_next = ent_q[rd_idx];
				end else begin
					stat_next = spq_pkg::STAT_RANGE;
				end
			end
			spq_pkg::CMD_CLEAR: begin
				count_next = '0;
			end
			default: begin
				count_next = count_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= in_command;
			val_q <= in_value;
			pos_q <= in_position;
		end
		if (cmd.exec) begin
			status      <= stat_next;
			read_value  <= rd_next;
			entry_count <= spq_pkg::ECNT_W'(count_next);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_next;
		end
	end

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= spq_pkg::CNT_W'(spq_pkg::CAPACITY))
		else $error("entry count beyond capacity");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && cmd_q == spq_pkg::CMD_CLEAR) |=> (count_q == '0))
		else $error("clear left entries");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		do_ins |=> (count_q == $past(count_q) + 1'b1))
		else $error("insert did not add one entry");

endmodule

// File: test/sorted_priority_queue_top_tb.sv
// Self-checking testbench for sorted_priority_queue_top: a directed table, then random traffic.
// Keeps a shadow copy of the sorted list; needs spq_pkg and the RTL of the block.
module sorted_priority_queue_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic signed [spq_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [spq_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam int ITEMS_PER_PHASE = 617;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [spq_pkg::STAT_W-1:0]        status;
		logic signed [spq_pkg::DATA_W-1:0] read_value;
		logic [spq_pkg::ECNT_W-1:0]        entry_count;
	} spq_result_t;

	// One row of the directed table: the command is sent reps times. Where
	// typed is set, the expected result is the one written in the row.
	typedef struct {
		logic [spq_pkg::CMD_W-1:0]         cmd;
		logic signed [spq_pkg::DATA_W-1:0] val;
		logic [spq_pkg::POS_W-1:0]         pos;
		int                                reps;
		bit                                typed;
		spq_result_t                       want;
	} cmd_row_t;

	localparam spq_result_t NO_WANT = '{spq_pkg::STAT_DONE, 32'sd0, 5'd0};

	cmd_row_t opening_cmds [0:18] = '{
		'{spq_pkg::CMD_READ,   32'sd0,  4'd0,  1, 1'b1,
			'{spq_pkg::STAT_RANGE,     32'sd0, 5'd0}},
		'{spq_pkg::CMD_REMOVE, 32'sd0,  4'd0,  1, 1'b1,
			'{spq_pkg::STAT_NOT_FOUND, 32'sd0, 5'd0}},
		'{spq_pkg::CMD_INSERT, VAL_MAX, 4'd0,  1, 1'b1,
			'{spq_pkg::STAT_DONE,      32'sd0, 5'd1}},
		'{spq_pkg::CMD_INSERT, VAL_MIN, 4'd0,  1, 1'b1,
			'{spq_pkg::STAT_DONE,      32'sd0, 5'd2}},
		'{spq_pkg::CMD_INSERT, 32'sd0,  4'd0,  1, 1'b0, NO_WANT},
		'{spq_pkg::CMD_READ,   32'sd0,  4'd0,  1, 1'b1,
			'{spq_pkg::STAT_DONE,      VAL_MAX, 5'd3}},
		'{spq_pkg::CMD_READ,   32'sd0,  4'd2,  1, 1'b1,
			'{spq_pkg::STAT_DONE,      VAL_MIN, 5'd3}},
		'{spq_pkg::CMD_READ,   32'sd0,  4'd15, 1, 1'b1,
			'{spq_pkg::STAT_RANGE,     32'sd0, 5'd3}},
		'{spq_pkg::CMD_REMOVE, 32'sd5,  4'd0,  1, 1'b1,
			'{spq_pkg::STAT_NOT_FOUND, 32'sd0, 5'd3}},
		'{spq_pkg::CMD_INSERT, -32'sd1, 4'd15, 1, 1'b0, NO_WANT},
		// Twelve equal values fill the list; the newest of equals goes first.
		'{spq_pkg::CMD_INSERT, 32'sd7,  4'd0, 12, 1'b0, NO_WANT},
		'{spq_pkg::CMD_INSERT, 32'sd1,  4'd0,  1, 1'b1,
			'{spq_pkg::STAT_FULL,      32'sd0, 5'd16}},
		'{spq_pkg::CMD_READ,   32'sd0,  4'd15, 1, 1'b1,
			'{spq_pkg::STAT_DONE,      VAL_MIN, 5'd16}},
		'{spq_pkg::CMD_REMOVE, 32'sd7,  4'd0,  1, 1'b0, NO_WANT},
		'{spq_pkg::CMD_REMOVE, VAL_MIN, 4'd0,  1, 1'b0, NO_WANT},
		'{spq_pkg::CMD_CLEAR,  VAL_MAX, 4'd15, 1, 1'b1,
			'{spq_pkg::STAT_DONE,      32'sd0, 5'd0}},
		'{spq_pkg::CMD_READ,   32'sd0,  4'd0,  1, 1'b1,
			'{spq_pkg::STAT_RANGE,     32'sd0, 5'd0}},
		'{spq_pkg::CMD_INSERT, -32'sd5, 4'd0,  1, 1'b0, NO_WANT},
		'{spq_pkg::CMD_REMOVE, -32'sd5, 4'd0,  1, 1'b1,
			'{spq_pkg::STAT_DONE,      32'sd0, 5'd0}}
	};

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [spq_pkg::S_TDATA_W-1:0] s_tdata;
	logic [spq_pkg::S_TUSER_W-1:0] s_tuser;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [spq_pkg::M_TDATA_W-1:0] m_tdata;
	logic [spq_pkg::M_TUSER_W-1:0] m_tuser;

	sorted_priority_queue_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	// Shadow copy of the list, kept in step with accepted command beats.
	logic signed [spq_pkg::DATA_W-1:0] shadow_list [spq_pkg::CAPACITY];
	int                                shadow_count = 0;
	spq_result_t                       due_results [$];
	int                                err_count = 0;
	longint                            cycle_count = 0;

	// Idle rates in percent, changed between phases of the run.
	int  send_idle = 0;
	int  recv_idle = 0;
	// Written expectation of the beat now on the command bus, if any.
	bit          beat_typed = 1'b0;
	spq_result_t beat_want;

	// Applies one command to the shadow list and returns the result it gives.
	function automatic spq_result_t sorted_list_apply(logic [spq_pkg::CMD_W-1:0] cmd,
			logic signed [spq_pkg::DATA_W-1:0] val, logic [spq_pkg::POS_W-1:0] pos);
		spq_result_t res;
		int at;
		int i;
		res = '{spq_pkg::STAT_DONE, 32'sd0, 5'd0};
		at = 0;
		case (cmd)
			spq_pkg::CMD_INSERT: begin
				if (shadow_count >= spq_pkg::CAPACITY) begin
					res.status = spq_pkg::STAT_FULL;
				end else begin
					while (at < shadow_count && shadow_list[at] > val)
						at++;
					for (i = shadow_count; i > at; i--)
						shadow_list[i] = shadow_list[i-1];
					shadow_list[at] = val;
					shadow_count++;
				end
			end
			spq_pkg::CMD_REMOVE: begin
				while (at < shadow_count && shadow_list[at] != val)
					at++;
				if (at >= shadow_count) begin
					res.status = spq_pkg::STAT_NOT_FOUND;
				end else begin
					for (i = at; i + 1 < shadow_count; i++)
						shadow_list[i] = shadow_list[i+1];
					shadow_count--;
				end
			end
			spq_pkg::CMD_READ: begin
				if (int'(pos) >= shadow_count)
					res.status = spq_pkg::STAT_RANGE;
				else
					res.read_value = shadow_list[pos];
			end
			default: begin
				shadow_count = 0;
			end
		endcase
		res.entry_count = spq_pkg::ECNT_W'(shadow_count);
		return res;
	endfunction

	// Values lean toward a small pool (so removes and ties hit) and the extremes.
	function automatic logic signed [spq_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(7))
			0, 1: return $signed(spq_pkg::DATA_W'($urandom_range(4))) - 32'sd2;
			2: begin
				case ($urandom_range(3))
					0: return VAL_MAX;
					1: return VAL_MIN;
					2: return VAL_MAX - 32'sd1;
					default: return VAL_MIN + 32'sd1;
				endcase
			end
			default: return $signed(spq_pkg::DATA_W'($urandom));
		endcase
	endfunction

	// Random command; grow mode favors inserts so the list reaches full,
	// shrink mode favors removes so it drains to empty.
	task automatic pick_command(input bit grow, output logic [spq_pkg::CMD_W-1:0] cmd,
			output logic signed [spq_pkg::DATA_W-1:0] val,
			output logic [spq_pkg::POS_W-1:0] pos);
		int roll;
		roll = $urandom_range(99);
		val = pick_value();
		pos = spq_pkg::POS_W'($urandom);
		if (roll < (grow ? 60 : 20))
			cmd = spq_pkg::CMD_INSERT;
		else if (roll < (grow ? 75 : 68))
			cmd = spq_pkg::CMD_REMOVE;
		else if (roll < 98)
			cmd = spq_pkg::CMD_READ;
		else
			cmd = spq_pkg::CMD_CLEAR;
		if (cmd == spq_pkg::CMD_REMOVE && shadow_count > 0 && $urandom_range(3) != 0)
			val = shadow_list[$urandom_range(shadow_count - 1)];
		if (cmd == spq_pkg::CMD_READ && shadow_count > 0 && $urandom_range(9) < 7)
			pos = spq_pkg::POS_W'($urandom_range(shadow_count - 1));
	endtask

	// Presents one command beat, starting at a falling edge, and returns at the
	// falling edge after it was taken. Random gaps come before the beat.
	task automatic send_command(input logic [spq_pkg::CMD_W-1:0] cmd,
			input logic signed [spq_pkg::DATA_W-1:0] val,
			input logic [spq_pkg::POS_W-1:0] pos,
			input bit typed, input spq_result_t want);
		logic [spq_pkg::S_TDATA_W-1:0] data;
		logic [spq_pkg::S_TUSER_W-1:0] user;
		data = '0;
		user = '0;
		data[spq_pkg::DATA_W-1:0] = val;
		data[spq_pkg::DATA_W +: spq_pkg::POS_W] = pos;
		user[spq_pkg::CMD_W-1:0] = cmd;
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		beat_typed = typed;
		beat_want = want;
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tuser <= user;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Receiver stalls are redrawn every falling edge.
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	// Command beats are predicted and result beats checked at the same edge;
	// the push comes first so a result in the same cycle would still match.
	always @(posedge clk) begin
		spq_result_t pred;
		spq_result_t got;
		spq_result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				pred = sorted_list_apply(s_tuser[spq_pkg::CMD_W-1:0],
						$signed(s_tdata[spq_pkg::DATA_W-1:0]),
						s_tdata[spq_pkg::DATA_W +: spq_pkg::POS_W]);
				due_results.push_back(beat_typed ? beat_want : pred);
			end
			if (m_tvalid && m_tready) begin
				got.status = m_tuser[spq_pkg::STAT_W-1:0];
				got.read_value = $signed(m_tdata[spq_pkg::DATA_W-1:0]);
				got.entry_count = m_tdata[spq_pkg::DATA_W +: spq_pkg::ECNT_W];
				if (due_results.size() == 0) begin
					err_count++;
					$display("%0t: result beat with none expected: status %0d value %0d count %0d",
							$time, got.status, got.read_value, got.entry_count);
				end else begin
					want = due_results.pop_front();
					if (got != want) begin
						err_count++;
						if (got.status != want.status)
							$display("%0t: status expected %0d, got %0d",
									$time, want.status, got.status);
						if (got.read_value != want.read_value)
							$display("%0t: read_value expected %0d, got %0d",
									$time, want.read_value, got.read_value);
						if (got.entry_count != want.entry_count)
							$display("%0t: entry_count expected %0d, got %0d",
									$time, want.entry_count, got.entry_count);
					end
				end
			end
		end
	end

	// Watchdog for a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		logic [spq_pkg::CMD_W-1:0]         cmd;
		logic signed [spq_pkg::DATA_W-1:0] val;
		logic [spq_pkg::POS_W-1:0]         pos;
		bit                                grow;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		beat_want = NO_WANT;
		grow = 1'b1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle = 19;
		recv_idle = 84;
		foreach (opening_cmds[r]) begin
			for (int k = 0; k < opening_cmds[r].reps; k++)
				send_command(opening_cmds[r].cmd, opening_cmds[r].val, opening_cmds[r].pos,
						opening_cmds[r].typed, opening_cmds[r].want);
		end

		// Three phases: slow receiver, slow sender, then full rate.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 19 : (phase == 1) ? 84 : 0;
			recv_idle = (phase == 0) ? 84 : (phase == 1) ? 19 : 0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (n % 64 == 0)
					grow = $urandom_range(1);
				pick_command(grow, cmd, val, pos);
				send_command(cmd, val, pos, 1'b0, NO_WANT);
			end
		end
		s_tvalid <= 1'b0;

		while (due_results.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
